// ===== rtl/core/event_fifo_with_type_counters_unit_assert.svh =====
// ----------------------------------------------------------------------------
// event fifo assertion macros
// shared property forms for the checker, clocked on clk, idle in reset
// ----------------------------------------------------------------------------
`ifndef EVENT_FIFO_WITH_TYPE_COUNTERS_UNIT_ASSERT_SVH
`define EVENT_FIFO_WITH_TYPE_COUNTERS_UNIT_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define EFC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define EFC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/efc_pkg.sv =====
// ----------------------------------------------------------------------------
// efc_pkg
// types, constants and codes shared by the event fifo modules
// ----------------------------------------------------------------------------
package efc_pkg;

    localparam int DEPTH      = 32;
    localparam int NUM_TYPES  = 16;
    localparam logic [7:0] VOID_TYPE = 8'd0;

    localparam int PTR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int TYPE_IDX_W = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;

    localparam int CMDQ_DEPTH = 2;

    // opcodes
    localparam logic [1:0] OP_PUSH  = 2'd0;
    localparam logic [1:0] OP_POP   = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;
    localparam logic [1:0] ST_HALTED   = 2'd3;

    localparam logic [7:0] PEND_SAT   = 8'd254;
    localparam logic [7:0] PEND_EMPTY = 8'd255;

    // config register indexes
    localparam logic REG_OVF_MON = 1'b0;

    typedef enum logic [1:0] {
        CMD_PUSH  = 2'd0,
        CMD_POP   = 2'd1,
        CMD_QUERY = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic        in_range;
        logic        is_void;
        logic [7:0]  event_id;
        logic [31:0] aux_data;
        logic [63:0] timestamp;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic not_empty;
    } cmdq_status_t;

endpackage

// ===== rtl/core/efc_front.sv =====
// ----------------------------------------------------------------------------
// efc_front
// accepts input beats and classifies them into queue commands
// ----------------------------------------------------------------------------
module efc_front (
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            opcode,
    input  logic [7:0]            event_id,
    input  logic [31:0]           aux_data,
    input  logic [63:0]           timestamp_us,
    input  efc_pkg::cmdq_status_t q_status,
    output logic                  q_push,
    output efc_pkg::cmd_t         q_cmd
);
    import efc_pkg::*;

    assign in_ready = !q_status.full;
    assign q_push   = in_valid && !q_status.full;

    always_comb
    begin
        q_cmd           = '0;
        q_cmd.event_id  = event_id;
        q_cmd.aux_data  = aux_data;
        q_cmd.timestamp = timestamp_us;
        q_cmd.in_range  = (32'(event_id) < 32'(NUM_TYPES));
        q_cmd.is_void   = (event_id == VOID_TYPE);
        unique case (opcode)
            OP_PUSH:  q_cmd.kind = CMD_PUSH;
            OP_POP:   q_cmd.kind = CMD_POP;
            OP_QUERY: q_cmd.kind = CMD_QUERY;
            default:  q_cmd.kind = CMD_NOP;
        endcase
    end

endmodule

// ===== rtl/core/efc_cmd_queue.sv =====
// ----------------------------------------------------------------------------
// efc_cmd_queue
// two-entry command queue between the front and the back
// ----------------------------------------------------------------------------
module efc_cmd_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  efc_pkg::cmd_t         push_cmd,
    input  logic                  pop,
    output efc_pkg::cmd_t         head_cmd,
    output efc_pkg::cmdq_status_t status
);
    import efc_pkg::*;

    localparam int QP_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
    localparam int QC_W = $clog2(CMDQ_DEPTH + 1);

    cmd_t            slot_reg [CMDQ_DEPTH];
    logic [QP_W-1:0] wr_reg, wr_next;
    logic [QP_W-1:0] rd_reg, rd_next;
    logic [QC_W-1:0] cnt_reg, cnt_next;

    function automatic logic [QP_W-1:0] bump(input logic [QP_W-1:0] p);
        bump = (32'(p) == CMDQ_DEPTH - 1) ? '0 : p + 1'b1;
    endfunction

    assign status.full      = (32'(cnt_reg) == CMDQ_DEPTH);
    assign status.not_empty = (cnt_reg != '0);
    assign head_cmd         = slot_reg[rd_reg];

    always_comb
    begin
        wr_next  = push ? bump(wr_reg) : wr_reg;
        rd_next  = pop ? bump(rd_reg) : rd_reg;
        cnt_next = cnt_reg + QC_W'(push) - QC_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_reg] <= push_cmd;
    end

endmodule

// ===== rtl/core/efc_back.sv =====
// ----------------------------------------------------------------------------
// efc_back
// executes queued commands on the ring buffer and counters, holds the result
// ----------------------------------------------------------------------------
module efc_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  efc_pkg::cmdq_status_t q_status,
    input  efc_pkg::cmd_t         q_cmd,
    output logic                  q_pop,
    input  logic [4:0]            ovf_monitor,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [1:0]            status,
    output logic [7:0]            out_event_id,
    output logic [31:0]           out_aux_data,
    output logic [63:0]           out_timestamp,
    output logic [7:0]            pending,
    output logic [31:0]           stat_count,
    output logic [4:0]            monitor_mark
);
    import efc_pkg::*;

    // ring buffer storage
    logic [7:0]  type_mem [DEPTH];
    logic [31:0] aux_mem  [DEPTH];
    logic [63:0] time_mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [31:0]      type_cnt_reg [NUM_TYPES];
    logic [31:0]      total_reg, total_next;
    logic             halted_reg, halted_next;
    logic             out_valid_reg, out_valid_next;

    logic [1:0]  status_reg, status_next;
    logic [7:0]  pending_reg, pending_next;
    logic [31:0] stat_reg, stat_next;
    logic [4:0]  mark_reg, mark_next;
    logic [7:0]  oid_reg;
    logic [31:0] oaux_reg;
    logic [63:0] ots_reg;

    logic                  take;
    logic                  mem_we;
    logic                  pop_rd;
    logic                  cnt_we;
    logic [TYPE_IDX_W-1:0] type_idx;
    logic [CNT_W-1:0]      left;

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
        next_slot = (32'(p) == DEPTH - 1) ? '0 : p + 1'b1;
    endfunction

    assign take     = q_status.not_empty && (!out_valid_reg || out_ready);
    assign q_pop    = take;
    assign type_idx = q_cmd.event_id[TYPE_IDX_W-1:0];
    assign left     = fill_reg - 1'b1;

    always_comb
    begin
        wr_ptr_next  = wr_ptr_reg;
        rd_ptr_next  = rd_ptr_reg;
        fill_next    = fill_reg;
        total_next   = total_reg;
        halted_next  = halted_reg;
        status_next  = status_reg;
        pending_next = pending_reg;
        stat_next    = stat_reg;
        mark_next    = mark_reg;
        mem_we       = 1'b0;
        pop_rd       = 1'b0;
        cnt_we       = 1'b0;
        if (take)
        begin
            status_next  = ST_OK;
            pending_next = '0;
            stat_next    = '0;
            mark_next    = '0;
            if (halted_reg)
            begin
                status_next = ST_HALTED;
            end
            else
            begin
                unique case (q_cmd.kind)
                    CMD_PUSH:
                    begin
                        if (32'(fill_reg) == DEPTH)
                        begin
                            halted_next = 1'b1;
                            status_next = ST_OVERFLOW;
                            mark_next   = ovf_monitor;
                        end
                        else
                        begin
                            mem_we      = 1'b1;
                            wr_ptr_next = next_slot(wr_ptr_reg);
                            fill_next   = fill_reg + 1'b1;
                            cnt_we      = q_cmd.in_range;
                            total_next  = total_reg + 32'd1;
                        end
                    end
                    CMD_POP:
                    begin
                        if (fill_reg == '0)
                        begin
                            status_next  = ST_EMPTY;
                            pending_next = PEND_EMPTY;
                        end
                        else
                        begin
                            pop_rd       = 1'b1;
                            rd_ptr_next  = next_slot(rd_ptr_reg);
                            fill_next    = left;
                            pending_next = (32'(left) > 32'(PEND_SAT)) ? PEND_SAT : 8'(left);
                        end
                    end
                    CMD_QUERY:
                    begin
                        if (q_cmd.is_void)
                            stat_next = total_reg;
                        else if (q_cmd.in_range)
                            stat_next = type_cnt_reg[type_idx];
                    end
                    CMD_NOP:
                    begin
                        status_next = ST_OK;
                    end
                    default:
                    begin
                        status_next = ST_OK;
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        if (take)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            fill_reg      <= '0;
            total_reg     <= '0;
            halted_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_TYPES; i++)
                type_cnt_reg[i] <= '0;
        end
        else
        begin
            wr_ptr_reg    <= wr_ptr_next;
            rd_ptr_reg    <= rd_ptr_next;
            fill_reg      <= fill_next;
            total_reg     <= total_next;
            halted_reg    <= halted_next;
            out_valid_reg <= out_valid_next;
            if (cnt_we)
                type_cnt_reg[type_idx] <= type_cnt_reg[type_idx] + 32'd1;
        end
    end

    // ring buffer write port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            type_mem[wr_ptr_reg] <= q_cmd.event_id;
            aux_mem[wr_ptr_reg]  <= q_cmd.aux_data;
            time_mem[wr_ptr_reg] <= q_cmd.timestamp;
        end
    end

    // registered read port and result payload
    always_ff @(posedge clk)
    begin
        status_reg  <= status_next;
        pending_reg <= pending_next;
        stat_reg    <= stat_next;
        mark_reg    <= mark_next;
        if (take)
        begin
            if (pop_rd)
            begin
                oid_reg  <= type_mem[rd_ptr_reg];
                oaux_reg <= aux_mem[rd_ptr_reg];
                ots_reg  <= time_mem[rd_ptr_reg];
            end
            else
            begin
                oid_reg  <= '0;
                oaux_reg <= '0;
                ots_reg  <= '0;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign out_event_id  = oid_reg;
    assign out_aux_data  = oaux_reg;
    assign out_timestamp = ots_reg;
    assign pending       = pending_reg;
    assign stat_count    = stat_reg;
    assign monitor_mark  = mark_reg;

endmodule

// ===== rtl/core/event_fifo_with_type_counters_unit.sv =====
// ----------------------------------------------------------------------------
// event_fifo_with_type_counters_unit
// circular event queue with per-type and total push counters
// ----------------------------------------------------------------------------
// an input beat passes through the command queue, then the result register, to become a result beat
// throughput: one item per cycle while out_ready holds; the back executes one queued command per cycle
// a full command queue or an unread result register stalls input
// reset clears pointers, fill count, counters, halt flag and overflow_monitor
// event storage is not cleared; there is no clearing pass after reset
module event_fifo_with_type_counters_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  opcode,
    input  logic [7:0]  event_id,
    input  logic [31:0] aux_data,
    input  logic [63:0] timestamp_us,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [7:0]  out_event_id,
    output logic [31:0] out_aux_data,
    output logic [63:0] out_timestamp,
    output logic [7:0]  pending,
    output logic [31:0] stat_count,
    output logic [4:0]  monitor_mark
);
    import efc_pkg::*;

    logic [4:0]   ovf_mon_reg;
    logic         q_push;
    logic         q_pop;
    cmd_t         push_cmd;
    cmd_t         head_cmd;
    cmdq_status_t q_status;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_OVF_MON) ? {27'd0, ovf_mon_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ovf_mon_reg <= '0;
        else if (psel && penable && pwrite && (paddr[2] == REG_OVF_MON))
            ovf_mon_reg <= pwdata[4:0];
    end

    efc_front u_front (
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .opcode       (opcode),
        .event_id     (event_id),
        .aux_data     (aux_data),
        .timestamp_us (timestamp_us),
        .q_status     (q_status),
        .q_push       (q_push),
        .q_cmd        (push_cmd)
    );

    efc_cmd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .head_cmd (head_cmd),
        .status   (q_status)
    );

    efc_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_status      (q_status),
        .q_cmd         (head_cmd),
        .q_pop         (q_pop),
        .ovf_monitor   (ovf_mon_reg),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .out_event_id  (out_event_id),
        .out_aux_data  (out_aux_data),
        .out_timestamp (out_timestamp),
        .pending       (pending),
        .stat_count    (stat_count),
        .monitor_mark  (monitor_mark)
    );

endmodule

// ===== rtl/core/efc_checker.sv =====
// ----------------------------------------------------------------------------
// efc_checker
// port-level checks on the event fifo result channel, bound to the top level
// ----------------------------------------------------------------------------
`include "event_fifo_with_type_counters_unit_assert.svh"

module efc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  status,
    input logic [7:0]  out_event_id,
    input logic [7:0]  pending,
    input logic [31:0] stat_count,
    input logic [4:0]  monitor_mark
);
    import efc_pkg::*;

    logic seen_ovf_reg;

    // remembers that an overflow beat has gone out
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seen_ovf_reg <= 1'b0;
        else if (out_valid && out_ready && (status == ST_OVERFLOW))
            seen_ovf_reg <= 1'b1;
    end

    `EFC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(pending) && $stable(stat_count), "result beat changed while stalled")
    `EFC_ASSERT_NOW(a_halt_sticky, out_valid && seen_ovf_reg, status == ST_HALTED, "result after overflow is not halted")
    `EFC_ASSERT_NOW(a_empty_pop, out_valid && (status == ST_EMPTY), (pending == PEND_EMPTY) && (out_event_id == 8'd0) && (stat_count == 32'd0), "empty pop result malformed")
    `EFC_ASSERT_NOW(a_halted_zero, out_valid && (status == ST_HALTED), (pending == 8'd0) && (stat_count == 32'd0) && (monitor_mark == 5'd0), "halted result carries data")

endmodule

bind event_fifo_with_type_counters_unit efc_checker u_efc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .out_event_id (out_event_id),
    .pending      (pending),
    .stat_count   (stat_count),
    .monitor_mark (monitor_mark)
);
